[rtl/csys_pkg.sv]
// ----------------------------------------------------------------------------
// csys_pkg - shared types and constants for the circular shift yaw search
// Holds the sequencer states, the lag cell control group and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package csys_pkg;

  // default geometry
  localparam int DESC_LEN_DEF  = 64;
  localparam int BIN_WIDTH_DEF = 16;

  // fixed port widths
  localparam int IN_W     = 16;
  localparam int SHIFT_W  = 6;
  localparam int SSHIFT_W = 7;
  localparam int YAW_W    = 15;

  // 2*pi in Q44, rounded
  localparam logic [63:0] TWO_PI_Q44 = 64'h0000_6487_ED51_10B5;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_CORR,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // control group broadcast to every lag cell
  typedef struct packed {
    logic shift;      // q/r rings take their neighbour's value
    logic prod_en;    // register q * broadcast ref
    logic acc_clr;
    logic acc_add;
    logic acc_shift;  // accumulators move one cell towards cell 0
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/csys_lag_cell.sv]
// ----------------------------------------------------------------------------
// csys_lag_cell - one lag cell of the correlation ring
// Holds one query bin, one reference bin and the running sum for one shift.
// ----------------------------------------------------------------------------
`default_nettype none

module csys_lag_cell #(
  parameter int BIN_WIDTH = csys_pkg::BIN_WIDTH_DEF,
  parameter int ACC_W     = 2 * csys_pkg::BIN_WIDTH_DEF + $clog2(csys_pkg::DESC_LEN_DEF)
) (
  input  wire                       clk,
  input  csys_pkg::cell_ctrl_t      ctrl,
  input  wire  [BIN_WIDTH-1:0]      q_in,
  input  wire  [BIN_WIDTH-1:0]      r_in,
  input  wire  [BIN_WIDTH-1:0]      bcast,
  input  wire  [ACC_W-1:0]          acc_in,
  output logic [BIN_WIDTH-1:0]      q_out,
  output logic [BIN_WIDTH-1:0]      r_out,
  output logic [ACC_W-1:0]          acc_out
);
  import csys_pkg::*;

  localparam int PROD_W = 2 * BIN_WIDTH;

  logic [BIN_WIDTH-1:0] q_r;
  logic [BIN_WIDTH-1:0] r_r;
  logic [PROD_W-1:0]    prod_r;
  logic [ACC_W-1:0]     acc_r;

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      q_r <= q_in;
      r_r <= r_in;
    end
    if (ctrl.prod_en) begin
      prod_r <= PROD_W'(q_r) * PROD_W'(bcast);
    end
    if (ctrl.acc_clr) begin
      acc_r <= '0;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end else if (ctrl.acc_shift) begin
      acc_r <= acc_in;
    end
  end

  assign q_out   = q_r;
  assign r_out   = r_r;
  assign acc_out = acc_r;

endmodule

`default_nettype wire

[rtl/circular_shift_yaw_search_unit.sv]
// ----------------------------------------------------------------------------
// circular_shift_yaw_search_unit - circular correlation argmax with yaw out
// Loads query/reference bins into a ring of lag cells, correlates all shifts
// in parallel, scans the sums for the best shift and converts it to yaw.
// ----------------------------------------------------------------------------
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+------------------
//  input    | in_query_bin, in_ref_bin, in_match_found      | start & !busy
//  result   | out_best_shift, out_signed_shift, out_yaw_q12 | out_valid, 1 cycle
//
//  One bin pair is taken per cycle while loading. The request carrying the
//  last bin with a match starts the search: multiply-accumulate across the
//  cell ring, then the sums shift past the compare at cell 0, then the yaw
//  table is read; busy stays high through the search. Without a match the
//  zero result is registered and shows in the cycle after the last request.
//  Synchronous active-low reset returns to loading at bin 0. The receiver
//  cannot stall; each result is presented for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_shift_yaw_search_unit #(
  parameter int DESC_LEN  = csys_pkg::DESC_LEN_DEF,
  parameter int BIN_WIDTH = csys_pkg::BIN_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  output logic                              busy,
  input  wire  [csys_pkg::IN_W-1:0]         in_query_bin,
  input  wire  [csys_pkg::IN_W-1:0]         in_ref_bin,
  input  wire                               in_match_found,
  output logic                              out_valid,
  output logic [csys_pkg::SHIFT_W-1:0]      out_best_shift,
  output logic signed [csys_pkg::SSHIFT_W-1:0] out_signed_shift,
  output logic signed [csys_pkg::YAW_W-1:0] out_yaw_q12
);
  import csys_pkg::*;

  localparam int BC_W  = (DESC_LEN > 1) ? $clog2(DESC_LEN) : 1;
  localparam int CNT_W = $clog2(DESC_LEN + 1);
  localparam int ACC_W = 2 * BIN_WIDTH + BC_W;
  localparam int IW    = BC_W + 1;
  localparam int HALF  = DESC_LEN / 2;
  localparam int MAG_W = (HALF > 0) ? $clog2(HALF + 1) : 1;
  localparam int SW    = IW + SSHIFT_W;

  state_t     state_r, state_nxt;
  cell_ctrl_t ctrl;
  logic       load_sel;

  logic [BC_W-1:0]  bin_cnt_r;
  logic [CNT_W-1:0] step_r;
  logic [ACC_W-1:0] best_r;
  logic [BC_W-1:0]  best_idx_r;

  logic accept, last_bin;

  logic                       out_valid_r;
  logic [SHIFT_W-1:0]         shift_r;
  logic [SSHIFT_W-1:0]        sshift_r;
  logic [YAW_W-1:0]           yaw_r;

  logic [BIN_WIDTH-1:0] q_ring   [DESC_LEN];
  logic [BIN_WIDTH-1:0] r_ring   [DESC_LEN];
  logic [ACC_W-1:0]     acc_ring [DESC_LEN];
  logic [BIN_WIDTH-1:0] q_new, r_new;
  logic [IN_W+BIN_WIDTH-1:0] q_ext, r_ext;

  // bins wider than BIN_WIDTH lose their top bits; narrower ones zero-extend
  assign q_ext = {{BIN_WIDTH{1'b0}}, in_query_bin};
  assign r_ext = {{BIN_WIDTH{1'b0}}, in_ref_bin};
  assign q_new = q_ext[BIN_WIDTH-1:0];
  assign r_new = r_ext[BIN_WIDTH-1:0];

  assign busy     = (state_r != ST_LOAD);
  assign accept   = start && !busy;
  assign last_bin = (bin_cnt_r == BC_W'(DESC_LEN - 1));

  // lag cell ring; data moves from cell k+1 to cell k, q/r of cell 0 wrap round
  for (genvar k = 0; k < DESC_LEN; k++) begin : g_cell
    logic [BIN_WIDTH-1:0] q_in_k, r_in_k;
    logic [ACC_W-1:0]     acc_in_k;
    if (k == DESC_LEN - 1) begin : g_tail
      assign q_in_k   = load_sel ? q_new : q_ring[0];
      assign r_in_k   = load_sel ? r_new : r_ring[0];
      assign acc_in_k = '0;
    end else begin : g_body
      assign q_in_k   = q_ring[k+1];
      assign r_in_k   = r_ring[k+1];
      assign acc_in_k = acc_ring[k+1];
    end
    csys_lag_cell #(
      .BIN_WIDTH (BIN_WIDTH),
      .ACC_W     (ACC_W)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .q_in    (q_in_k),
      .r_in    (r_in_k),
      .bcast   (r_ring[0]),
      .acc_in  (acc_in_k),
      .q_out   (q_ring[k]),
      .r_out   (r_ring[k]),
      .acc_out (acc_ring[k])
    );
  end

  // yaw magnitude per shift magnitude, fixed at elaboration
  logic [YAW_W-1:0] yaw_tab [HALF+1];
  for (genvar m = 0; m <= HALF; m++) begin : g_yaw
    localparam logic [63:0] NUM = 64'(m) * TWO_PI_Q44 + (64'(DESC_LEN) << 31);
    localparam logic [63:0] YV  = NUM / (64'(DESC_LEN) << 32);
    assign yaw_tab[m] = YV[YAW_W-1:0];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    load_sel  = 1'b0;
    case (state_r)
      ST_LOAD: begin
        load_sel = 1'b1;
        if (accept) begin
          ctrl.shift = 1'b1;
          if (last_bin && in_match_found) begin
            state_nxt = ST_CORR;
          end
        end
      end
      ST_CORR: begin
        // product is registered, so the last add comes after shifting stops
        if (step_r != CNT_W'(DESC_LEN)) begin
          ctrl.shift   = 1'b1;
          ctrl.prod_en = 1'b1;
        end else begin
          state_nxt = ST_SCAN;
        end
        if (step_r == '0) begin
          ctrl.acc_clr = 1'b1;
        end else begin
          ctrl.acc_add = 1'b1;
        end
      end
      ST_SCAN: begin
        ctrl.acc_shift = 1'b1;
        if (step_r == CNT_W'(DESC_LEN - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        state_nxt = ST_LOAD;
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= '0;
      step_r    <= '0;
    end else begin
      if (accept) begin
        bin_cnt_r <= last_bin ? '0 : bin_cnt_r + 1'b1;
      end
      case (state_r)
        ST_CORR: step_r <= (step_r == CNT_W'(DESC_LEN)) ? '0 : step_r + 1'b1;
        ST_SCAN: step_r <= (step_r == CNT_W'(DESC_LEN - 1)) ? '0 : step_r + 1'b1;
        default: step_r <= '0;
      endcase
    end
  end

  // argmax: sums pass cell 0 in shift order; strict compare keeps the first
  always_ff @(posedge clk) begin
    if (state_r == ST_CORR && step_r == CNT_W'(DESC_LEN)) begin
      best_r     <= '0;
      best_idx_r <= '0;
    end else if (state_r == ST_SCAN && acc_ring[0] > best_r) begin
      best_r     <= acc_ring[0];
      best_idx_r <= step_r[BC_W-1:0];
    end
  end

  // shift to signed shift and yaw
  logic [IW-1:0]                shift_w, mag_w;
  logic                         neg_w;
  logic [SW-1:0]                sshift_w;
  logic [YAW_W-1:0]             yaw_mag_w;
  logic [SHIFT_W+BC_W-1:0]      shift_ext;

  always_comb begin
    shift_w   = IW'(best_idx_r);
    neg_w     = ({shift_w, 1'b0} > (IW+1)'(DESC_LEN));
    mag_w     = neg_w ? IW'(DESC_LEN) - shift_w : shift_w;
    yaw_mag_w = yaw_tab[mag_w[MAG_W-1:0]];
    sshift_w  = neg_w ? SW'(0) - SW'(mag_w) : SW'(mag_w);
    shift_ext = {{SHIFT_W{1'b0}}, best_idx_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (accept && last_bin && !in_match_found) || (state_r == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_EMIT) begin
      shift_r  <= shift_ext[SHIFT_W-1:0];
      sshift_r <= sshift_w[SSHIFT_W-1:0];
      yaw_r    <= neg_w ? YAW_W'(0) - yaw_mag_w : yaw_mag_w;
    end else if (accept && last_bin) begin
      // last bin: all fields zero; shown only without a match
      shift_r  <= '0;
      sshift_r <= '0;
      yaw_r    <= '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_best_shift   = shift_r;
  assign out_signed_shift = sshift_r;
  assign out_yaw_q12      = yaw_r;

endmodule

`default_nettype wire

[tb/csys_yaw_checker.sv]
// ----------------------------------------------------------------------------
// csys_yaw_checker - result predictor and scoreboard for the yaw search unit
// Mirrors the bin stores from accepted requests, predicts the best circular
// shift and yaw for every completed frame and compares each strobed result
// against the oldest prediction. Failure and outstanding counts go to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csys_yaw_checker #(
  parameter int DESC_LEN = csys_pkg::DESC_LEN_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire                                   busy,
  input  wire  [csys_pkg::IN_W-1:0]             in_query_bin,
  input  wire  [csys_pkg::IN_W-1:0]             in_ref_bin,
  input  wire                                   in_match_found,
  input  wire                                   out_valid,
  input  wire  [csys_pkg::SHIFT_W-1:0]          out_best_shift,
  input  wire  signed [csys_pkg::SSHIFT_W-1:0]  out_signed_shift,
  input  wire  signed [csys_pkg::YAW_W-1:0]     out_yaw_q12,
  output int                                    fail_count,
  output int                                    pending
);

  typedef struct packed {
    logic        [csys_pkg::SHIFT_W-1:0]  shift_idx;
    logic signed [csys_pkg::SSHIFT_W-1:0] signed_shift;
    logic signed [csys_pkg::YAW_W-1:0]    yaw_q12;
  } yaw_result_t;

  logic [csys_pkg::IN_W-1:0] query_bins [DESC_LEN];
  logic [csys_pkg::IN_W-1:0] ref_bins [DESC_LEN];
  int                        bins_loaded;
  int                        mismatches;
  yaw_result_t               expected_yaws [$];
  yaw_result_t               want;

  // full circular correlation over the mirrored stores, strict > keeps the
  // smallest shift on ties
  function automatic yaw_result_t predict_yaw(input logic match);
    yaw_result_t res;
    logic [63:0] acc;
    logic [63:0] top_sum;
    logic [63:0] yaw_mag;
    int          top_shift;
    int          mag;
    int          sshift;
    int          yaw_i;
    res = '0;
    if (!match) return res;
    top_sum = '0;
    top_shift = 0;
    for (int s = 0; s < DESC_LEN; s++) begin
      acc = '0;
      for (int j = 0; j < DESC_LEN; j++)
        acc += query_bins[(s + j) % DESC_LEN] * ref_bins[j];
      if (acc > top_sum) begin
        top_sum = acc;
        top_shift = s;
      end
    end
    // half the length stays positive
    mag = (2 * top_shift > DESC_LEN) ? DESC_LEN - top_shift : top_shift;
    sshift = (2 * top_shift > DESC_LEN) ? -mag : mag;
    yaw_mag = (64'(mag) * csys_pkg::TWO_PI_Q44 + (64'(DESC_LEN) << 31))
              / (64'(DESC_LEN) << 32);
    yaw_i = int'(yaw_mag);
    res.shift_idx    = csys_pkg::SHIFT_W'(top_shift);
    res.signed_shift = csys_pkg::SSHIFT_W'(sshift);
    res.yaw_q12      = csys_pkg::YAW_W'((sshift < 0) ? -yaw_i : yaw_i);
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      bins_loaded = 0;
      expected_yaws.delete();
    end else begin
      // results first: nothing accepted at this edge can be answered at it
      if (out_valid) begin
        if (expected_yaws.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result shift %0d sshift %0d yaw %0d", $realtime,
                     out_best_shift, out_signed_shift, out_yaw_q12);
        end else begin
          want = expected_yaws.pop_front();
          if (out_best_shift !== want.shift_idx || out_signed_shift !== want.signed_shift
              || out_yaw_q12 !== want.yaw_q12) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: yaw mismatch exp shift %0d sshift %0d yaw %0d, got %0d %0d %0d",
                       $realtime, want.shift_idx, $signed(want.signed_shift),
                       $signed(want.yaw_q12), out_best_shift, out_signed_shift,
                       out_yaw_q12);
          end
        end
      end
      if (start && !busy) begin
        query_bins[bins_loaded] = in_query_bin;
        ref_bins[bins_loaded] = in_ref_bin;
        bins_loaded++;
        if (bins_loaded == DESC_LEN) begin
          bins_loaded = 0;
          expected_yaws.insert(expected_yaws.size(), predict_yaw(in_match_found));
        end
      end
    end
    fail_count <= mismatches;
    pending <= expected_yaws.size();
  end

endmodule

[tb/tb_circular_shift_yaw_search_unit.sv]
// ----------------------------------------------------------------------------
// tb_circular_shift_yaw_search_unit - top level bench for the yaw search unit
// Drives whole descriptor frames, directed corner frames first (flat, tied,
// impulse at shifts 1, half length, one above it and the last, no match) then
// random frames of several shapes with random sender gaps. A checker beside
// the block predicts and scores every result; the top gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_circular_shift_yaw_search_unit;

  localparam int DESC_LEN = csys_pkg::DESC_LEN_DEF;

  typedef enum int {
    PAT_NOISE,
    PAT_ROTATED,
    PAT_SPARSE,
    PAT_TINY,
    PAT_ROTATED_NOISY
  } pattern_t;

  logic                                 clk = 1'b0;
  logic                                 rst_n;
  logic                                 start;
  logic                                 busy;
  logic [csys_pkg::IN_W-1:0]            in_query_bin;
  logic [csys_pkg::IN_W-1:0]            in_ref_bin;
  logic                                 in_match_found;
  logic                                 out_valid;
  logic [csys_pkg::SHIFT_W-1:0]         out_best_shift;
  logic signed [csys_pkg::SSHIFT_W-1:0] out_signed_shift;
  logic signed [csys_pkg::YAW_W-1:0]    out_yaw_q12;
  int                                   fail_count;
  int                                   pending;

  logic [csys_pkg::IN_W-1:0] frame_query [DESC_LEN];
  logic [csys_pkg::IN_W-1:0] frame_ref [DESC_LEN];
  int                        requests_sent;
  int                        idle_level;
  bit                        calm;

  always #10 clk = ~clk;

  circular_shift_yaw_search_unit i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_query_bin     (in_query_bin),
    .in_ref_bin       (in_ref_bin),
    .in_match_found   (in_match_found),
    .out_valid        (out_valid),
    .out_best_shift   (out_best_shift),
    .out_signed_shift (out_signed_shift),
    .out_yaw_q12      (out_yaw_q12)
  );

  csys_yaw_checker #(.DESC_LEN(DESC_LEN)) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_query_bin     (in_query_bin),
    .in_ref_bin       (in_ref_bin),
    .in_match_found   (in_match_found),
    .out_valid        (out_valid),
    .out_best_shift   (out_best_shift),
    .out_signed_shift (out_signed_shift),
    .out_yaw_q12      (out_yaw_q12),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    #5_000_000;
    $display("tb_circular_shift_yaw_search_unit: done, errors");
    $finish;
  end

  // one request; start stays high across back-to-back requests
  task automatic send_bin_pair(input logic [15:0] q, input logic [15:0] r, input logic m);
    if (!calm && idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_query_bin <= q;
    in_ref_bin <= r;
    in_match_found <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
  endtask

  // match flag only matters on the last bin, so earlier ones are noise
  task automatic send_frame(input logic match);
    calm = (requests_sent >= 1300);
    for (int i = 0; i < DESC_LEN; i++)
      send_bin_pair(frame_query[i], frame_ref[i],
                    (i == DESC_LEN - 1) ? match : 1'($urandom_range(0, 1)));
    idle_level = $urandom_range(0, 3);
  endtask

  task automatic fill_const(input logic [15:0] q, input logic [15:0] r);
    for (int i = 0; i < DESC_LEN; i++) begin
      frame_query[i] = q;
      frame_ref[i] = r;
    end
  endtask

  // single query peak against a reference peak at bin 0: best shift is k
  task automatic impulse_frame(input int k);
    fill_const('0, '0);
    frame_query[k] = 16'hFFFF;
    frame_ref[0] = 16'hFFFF;
    send_frame(1'b1);
  endtask

  task automatic random_frame();
    pattern_t pat;
    int       rot;
    pat = pattern_t'($urandom_range(0, 4));
    rot = $urandom_range(0, DESC_LEN - 1);
    case (pat)
      PAT_NOISE: begin
        for (int i = 0; i < DESC_LEN; i++) begin
          frame_query[i] = 16'($urandom_range(0, 16'hFFFF));
          frame_ref[i] = 16'($urandom_range(0, 16'hFFFF));
        end
      end
      PAT_ROTATED, PAT_ROTATED_NOISY: begin
        for (int i = 0; i < DESC_LEN; i++)
          frame_ref[i] = (pat == PAT_ROTATED) ? 16'($urandom_range(0, 16'hFFFF))
                                              : 16'($urandom_range(0, 4095));
        for (int i = 0; i < DESC_LEN; i++)
          frame_query[(rot + i) % DESC_LEN] = frame_ref[i] +
              ((pat == PAT_ROTATED) ? 16'd0 : 16'($urandom_range(0, 15)));
      end
      PAT_SPARSE: begin
        fill_const('0, '0);
        repeat ($urandom_range(1, 4)) begin
          frame_query[$urandom_range(0, DESC_LEN - 1)] = 16'($urandom_range(1, 16'hFFFF));
          frame_ref[$urandom_range(0, DESC_LEN - 1)] = 16'($urandom_range(1, 16'hFFFF));
        end
      end
      default: begin
        for (int i = 0; i < DESC_LEN; i++) begin
          frame_query[i] = 16'($urandom_range(0, 3));
          frame_ref[i] = 16'($urandom_range(0, 3));
        end
      end
    endcase
    send_frame($urandom_range(0, 7) != 0);
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_query_bin <= '0;
    in_ref_bin <= '0;
    in_match_found <= 1'b0;
    requests_sent = 0;
    idle_level = 2;
    calm = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all sums zero, then all sums equal
    fill_const('0, '0);
    send_frame(1'b1);
    fill_const(16'hFFFF, 16'hFFFF);
    send_frame(1'b1);
    fill_const(16'hAAAA, 16'h5555);
    send_frame(1'b1);
    impulse_frame(1);
    impulse_frame(DESC_LEN / 2);
    impulse_frame(DESC_LEN / 2 + 1);
    impulse_frame(DESC_LEN - 1);
    // two equal peaks: lower shift wins
    fill_const('0, '0);
    frame_query[5] = 16'd1000;
    frame_query[40] = 16'd1000;
    frame_ref[0] = 16'd1000;
    send_frame(1'b1);
    // strong correlation but no match
    for (int i = 0; i < DESC_LEN; i++) begin
      frame_query[i] = 16'($urandom_range(0, 16'hFFFF));
      frame_ref[i] = frame_query[i];
    end
    send_frame(1'b0);

    repeat (15) random_frame();

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2 * DESC_LEN + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("tb_circular_shift_yaw_search_unit: done, clean");
    else
      $display("tb_circular_shift_yaw_search_unit: done, errors");
    $finish;
  end

endmodule

[sim.f]
rtl/csys_pkg.sv
rtl/csys_lag_cell.sv
rtl/circular_shift_yaw_search_unit.sv
tb/csys_yaw_checker.sv
tb/tb_circular_shift_yaw_search_unit.sv
